// File: design/ffba_pkg.sv
package ffba_pkg;

  localparam int CELLS = 256;

  localparam int CNT_W = 9;
  localparam int IDX_W = 8;
  localparam int LIM_W = 9;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIT,
    ST_CHECK,
    ST_WRITE,
    ST_HIGH,
    ST_DONE
  } state_t;

endpackage

// File: design/first_fit_bitmap_allocator_unit.sv
// channel  | signals                                   | direction
// ---------+-------------------------------------------+----------
// cfg      | cfg_valid, cfg_ready, cfg_data            | in
// request  | in_valid, in_ready, command, run_length,  | in
//          | start_cell                                |
// result   | out_valid, out_ready, status, run_start,  | out
//          | last_used_cell                            |
//
// one request at a time through a single-bit map memory, one cell read per cycle.
// allocate: fit scan over up to L cells, n mark writes, top scan over L cells (L = limit).
// free: check of the n cells, n clear writes, then a top scan over L cells.
// after reset a clearing pass writes all CELLS cells before the first request is taken.
// the result sits in an output register, so a new request is taken while it waits.
module first_fit_bitmap_allocator_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ffba_pkg::LIM_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       command,
  input  logic [8:0]                 run_length,
  input  logic [7:0]                 start_cell,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       status,
  output logic [7:0]                 run_start,
  output logic [7:0]                 last_used_cell
);

  localparam int AW = $clog2(ffba_pkg::CELLS);

  ffba_pkg::state_t state, state_next;

  logic [ffba_pkg::LIM_W-1:0] cells_in_use;
  logic [ffba_pkg::LIM_W-1:0] lim;

  logic                       op_cmd;
  logic [ffba_pkg::CNT_W-1:0] op_len;
  logic [ffba_pkg::IDX_W-1:0] op_start;
  logic                       ok;
  logic [ffba_pkg::CNT_W-1:0] cnt;
  logic [ffba_pkg::CNT_W-1:0] end_cnt;
  logic                       pend;
  logic [ffba_pkg::IDX_W-1:0] pend_idx;
  logic [ffba_pkg::CNT_W-1:0] run;
  logic [ffba_pkg::IDX_W-1:0] at;
  logic [ffba_pkg::IDX_W-1:0] hi;
  logic [AW-1:0]              clr_addr;

  logic                       mem [0:ffba_pkg::CELLS-1];
  logic                       rdata;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic                       mem_wdata;
  logic [AW-1:0]              mem_raddr;

  logic                       accept;
  logic                       issue;
  logic                       scan_end;
  logic                       load_out;
  logic                       clr_last;
  logic [ffba_pkg::CNT_W-1:0] run_inc;
  logic                       found;
  logic [ffba_pkg::CNT_W-1:0] at_calc;
  logic [ffba_pkg::CNT_W:0]   free_end;
  logic                       alloc_bad;
  logic                       free_bad;

  assign lim = (32'(cells_in_use) > ffba_pkg::CELLS)
             ? ffba_pkg::LIM_W'(ffba_pkg::CELLS) : cells_in_use;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign scan_end  = (cnt == end_cnt) && !pend;
  assign clr_last  = (clr_addr == AW'(ffba_pkg::CELLS - 1));
  assign run_inc   = rdata ? '0 : run + 1'b1;
  assign found     = pend && (run_inc == op_len);
  assign at_calc   = {1'b0, pend_idx} + 9'd1 - op_len;
  assign free_end  = {2'b00, start_cell} + {1'b0, run_length};
  assign alloc_bad = (run_length == '0) || (run_length > lim);
  assign free_bad  = free_end > {1'b0, lim};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ffba_pkg::ST_CLEAR: begin
        if (clr_last) state_next = ffba_pkg::ST_IDLE;
      end
      ffba_pkg::ST_IDLE: begin
        if (accept) begin
          if (command == ffba_pkg::CMD_ALLOC) begin
            state_next = alloc_bad ? ffba_pkg::ST_HIGH : ffba_pkg::ST_FIT;
          end else begin
            state_next = (run_length == '0 || free_bad) ? ffba_pkg::ST_HIGH
                                                         : ffba_pkg::ST_CHECK;
          end
        end
      end
      ffba_pkg::ST_FIT: begin
        if (found) state_next = ffba_pkg::ST_WRITE;
        else if (scan_end) state_next = ffba_pkg::ST_HIGH;
      end
      ffba_pkg::ST_CHECK: begin
        if (scan_end) state_next = ok ? ffba_pkg::ST_WRITE : ffba_pkg::ST_HIGH;
      end
      ffba_pkg::ST_WRITE: begin
        if (cnt + 1'b1 == end_cnt) state_next = ffba_pkg::ST_HIGH;
      end
      ffba_pkg::ST_HIGH: begin
        if (scan_end) state_next = ffba_pkg::ST_DONE;
      end
      ffba_pkg::ST_DONE: begin
        if (!out_valid || out_ready) state_next = ffba_pkg::ST_IDLE;
      end
      default: state_next = ffba_pkg::ST_CLEAR;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    in_ready  = 1'b0;
    issue     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = AW'(cnt);
    mem_wdata = 1'b0;
    mem_raddr = AW'(cnt);
    load_out  = 1'b0;
    unique case (state)
      ffba_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      ffba_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      ffba_pkg::ST_FIT: begin
        issue = (cnt < end_cnt) && !found;
      end
      ffba_pkg::ST_CHECK, ffba_pkg::ST_HIGH: begin
        issue = cnt < end_cnt;
      end
      ffba_pkg::ST_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = (op_cmd == ffba_pkg::CMD_ALLOC);
      end
      ffba_pkg::ST_DONE: begin
        load_out = !out_valid || out_ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ffba_pkg::ST_CLEAR;
      cells_in_use <= 9'd256;
      clr_addr     <= '0;
      pend         <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) cells_in_use <= cfg_data;
      if (state == ffba_pkg::ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      pend <= issue && (state_next == state);
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (issue) begin
      cnt      <= cnt + 1'b1;
      pend_idx <= cnt[ffba_pkg::IDX_W-1:0];
    end
    unique case (state)
      ffba_pkg::ST_IDLE: begin
        if (accept) begin
          op_cmd   <= command;
          op_len   <= run_length;
          op_start <= start_cell;
          hi       <= '0;
          at       <= '0;
          run      <= '0;
          if (command == ffba_pkg::CMD_ALLOC) begin
            ok      <= 1'b0;
            cnt     <= '0;
            end_cnt <= lim;
          end else if (run_length == '0 || free_bad) begin
            ok      <= (run_length == '0);
            cnt     <= '0;
            end_cnt <= lim;
          end else begin
            ok      <= 1'b1;
            cnt     <= {1'b0, start_cell};
            end_cnt <= free_end[ffba_pkg::CNT_W-1:0];
          end
        end
      end
      ffba_pkg::ST_FIT: begin
        if (pend) run <= run_inc;
        if (found) begin
          ok      <= 1'b1;
          at      <= at_calc[ffba_pkg::IDX_W-1:0];
          cnt     <= at_calc;
          end_cnt <= at_calc + op_len;
        end else if (scan_end) begin
          cnt     <= '0;
          end_cnt <= lim;
        end
      end
      ffba_pkg::ST_CHECK: begin
        if (pend && !rdata) ok <= 1'b0;
        if (scan_end) begin
          if (ok) begin
            cnt     <= {1'b0, op_start};
            end_cnt <= {1'b0, op_start} + op_len;
          end else begin
            cnt     <= '0;
            end_cnt <= lim;
          end
        end
      end
      ffba_pkg::ST_WRITE: begin
        if (cnt + 1'b1 == end_cnt) begin
          cnt     <= '0;
          end_cnt <= lim;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      ffba_pkg::ST_HIGH: begin
        if (pend && rdata) hi <= pend_idx;
      end
      default: begin
      end
    endcase
    if (load_out) begin
      status         <= !ok;
      run_start      <= (ok && op_cmd == ffba_pkg::CMD_ALLOC) ? at : '0;
      last_used_cell <= hi;
    end
  end

endmodule
